/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MPCM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mpcm assertion failed: same-cycle implication");

// next-cycle implication
`define MPCM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mpcm assertion failed: next-cycle implication");

`endif

/* rtl/mpcm_pkg.sv */
// ---------------------------------------------------------------------------
// mpcm_pkg
// Command codes and field types of the multi-pattern character matcher.
// ---------------------------------------------------------------------------
`default_nettype none

package mpcm_pkg;

	typedef logic [1:0] cmd_t;

	localparam cmd_t CMD_FEED  = 2'd0;
	localparam cmd_t CMD_QUERY = 2'd1;
	localparam cmd_t CMD_CLEAR = 2'd2;
	localparam cmd_t CMD_LOAD  = 2'd3;

	localparam int FLAG_W = 8;

	typedef logic [FLAG_W-1:0] flags_t;

endpackage

`default_nettype wire

/* rtl/multi_pattern_char_matcher.sv */
// ---------------------------------------------------------------------------
// multi_pattern_char_matcher
// Streaming matcher of a character stream against PATTERNS stored patterns,
// each with its own progress index and a sticky match bit.
// ---------------------------------------------------------------------------
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------
//  item     | item_valid / item_stall    | command, pattern_sel, position,
//           |                            | char_value, last_byte
//  result   | result_valid / result_stall| found, match_flags
//
// One transaction per cycle sustained while result_stall is low. A
// transaction is registered at the input (s1), evaluated in a single pass
// against all patterns, and its result is registered in the result
// register. Each pattern's expected character is prefetched into a register
// from that pattern's own character memory. arst_n clears progress, lengths,
// match bits and both valid flags; pattern characters are not cleared.
// item_stall rises only while s1 holds a transaction and the result
// register is full and stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module multi_pattern_char_matcher
	import mpcm_pkg::*;
#(
	parameter int PATTERNS = 8,
	parameter int MAX_LEN  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        item_valid,
	output logic        item_stall,
	input  cmd_t        command,
	input  logic [2:0]  pattern_sel,
	input  logic [3:0]  position,
	input  logic [7:0]  char_value,
	input  logic        last_byte,
	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic        found,
	output flags_t      match_flags
);

	// progress / length need to hold MAX_LEN itself; addresses do not
	localparam int PW = $clog2(MAX_LEN + 1);
	localparam int AW = $clog2(MAX_LEN);
	// match vector widened to at least the visible flag count
	localparam int MW = (PATTERNS > FLAG_W) ? PATTERNS : FLAG_W;

	// ------------------------------------------------------------------
	// input register (s1)
	// ------------------------------------------------------------------
	logic              valid_s1;
	cmd_t              cmd_s1;
	logic [2:0]        sel_s1;
	logic [3:0]        pos_s1;
	logic [7:0]        char_s1;
	logic              last_s1;

	logic              accept_in;
	logic              advance;
	logic              fire;

	// result register
	logic              result_valid_q;
	logic              found_q;
	flags_t            flags_q;

	// pattern state
	logic [PW-1:0]     prog_q [PATTERNS];
	logic [PW-1:0]     prog_d [PATTERNS];
	logic [PW-1:0]     len_q  [PATTERNS];
	logic [PW-1:0]     len_d  [PATTERNS];
	logic [PATTERNS-1:0] match_q;
	logic [PATTERNS-1:0] match_d;
	logic              found_d;
	logic [MW-1:0]     match_ext;

	// character memories
	logic [PATTERNS-1:0] wr_en;
	logic [AW-1:0]     waddr;
	logic [7:0]        exp_char [PATTERNS];

	// the output register frees up when empty or being taken this cycle
	assign advance    = !result_valid_q || !result_stall;
	assign fire       = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;
	assign accept_in  = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			cmd_s1  <= command;
			sel_s1  <= pattern_sel;
			pos_s1  <= position;
			char_s1 <= char_value;
			last_s1 <= last_byte;
		end
	end

	// ------------------------------------------------------------------
	// single evaluation pass over all patterns
	// ------------------------------------------------------------------
	always_comb begin
		prog_d  = prog_q;
		len_d   = len_q;
		match_d = match_q;
		found_d = 1'b0;
		wr_en   = '0;
		if (fire) begin
			case (cmd_s1)
				CMD_FEED: begin
					for (int p = 0; p < PATTERNS; p++) begin
						if (len_q[p] != '0) begin
							// complete pattern reports one character late
							if (prog_q[p] >= len_q[p]) begin
								match_d[p] = 1'b1;
								found_d    = 1'b1;
							end else if (exp_char[p] == char_s1) begin
								prog_d[p] = prog_q[p] + PW'(1);
							end else begin
								prog_d[p] = '0;
							end
						end
					end
				end
				CMD_QUERY: begin
					for (int p = 0; p < PATTERNS; p++) begin
						if (32'(sel_s1) == p && match_q[p]) begin
							found_d    = 1'b1;
							match_d[p] = 1'b0;
						end
					end
				end
				CMD_CLEAR: begin
					prog_d  = '{default: '0};
					match_d = '0;
				end
				CMD_LOAD: begin
					if (32'(pos_s1) < MAX_LEN) begin
						for (int p = 0; p < PATTERNS; p++) begin
							if (32'(sel_s1) == p) begin
								wr_en[p]  = 1'b1;
								prog_d[p] = '0;
								if (last_s1) begin
									len_d[p] = PW'(pos_s1) + PW'(1);
								end
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_q  <= '{default: '0};
			len_q   <= '{default: '0};
			match_q <= '0;
		end else begin
			prog_q  <= prog_d;
			len_q   <= len_d;
			match_q <= match_d;
		end
	end

	// ------------------------------------------------------------------
	// per-pattern character memory; the read at the next progress index
	// is registered so the expected character is ready for the next item
	// ------------------------------------------------------------------
	assign waddr = AW'(pos_s1);

	for (genvar g = 0; g < PATTERNS; g++) begin : g_pat
		logic [7:0]    chars_mem [MAX_LEN];
		logic [AW-1:0] raddr;
		logic [7:0]    rd_q;
		logic          byp_q;
		logic [7:0]    byp_data_q;

		// progress equal to MAX_LEN wraps here; that byte is never compared
		assign raddr = AW'(prog_d[g]);

		always_ff @(posedge clk) begin
			if (wr_en[g]) begin
				chars_mem[waddr] <= char_s1;
			end
			rd_q       <= chars_mem[raddr];
			// forward a byte written to the address being fetched
			byp_q      <= wr_en[g] && (waddr == raddr);
			byp_data_q <= char_s1;
		end

		assign exp_char[g] = byp_q ? byp_data_q : rd_q;
	end

	// ------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------
	assign match_ext = MW'(match_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			found_q <= found_d;
			flags_q <= match_ext[FLAG_W-1:0];
		end
	end

	assign result_valid = result_valid_q;
	assign found        = found_q;
	assign match_flags  = flags_q;

endmodule

`default_nettype wire

/* rtl/mpcm_checker.sv */
// ---------------------------------------------------------------------------
// mpcm_checker
// Port-level assertions for the multi-pattern character matcher.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mpcm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_stall,
	input logic       result_valid,
	input logic       result_stall,
	input logic       found,
	input logic [7:0] match_flags
);

	// input side backs up only behind a full, stalled result
	`MPCM_ASSERT_IMP(a_stall_cause, clk, arst_n, item_stall, result_valid && result_stall)

	// a fresh result comes from an accepted transaction that passed through s1 and the result register
	`MPCM_ASSERT_IMP(a_result_latency, clk, arst_n, $rose(result_valid), $past(item_valid && !item_stall, 2))

	// held result keeps its payload
	`MPCM_ASSERT_NXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(found) && $stable(match_flags))

endmodule

bind multi_pattern_char_matcher mpcm_checker u_mpcm_checker (.*);

`default_nettype wire
